### hw/rtl/fcb_pkg.sv
// Package for the facility bit string block: field widths, flag masks,
// command, sequencer state and walk phase types. No dependencies.
package fcb_pkg;

  localparam int KIND_W      = 3;
  localparam int BITNUM_W    = 7;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 4;
  localparam int STORE_DEPTH = 16;

  localparam logic [BYTE_W-1:0] EXT_FLAG  = 8'h01;
  localparam logic [BYTE_W-1:0] EXT_CLEAR = 8'hFE;

  typedef enum logic [KIND_W-1:0] {
    K_CLEAR_ALL = 3'd0,
    K_LOAD      = 3'd1,
    K_SET       = 3'd2,
    K_CLEAR     = 3'd3,
    K_TEST      = 3'd4,
    K_READ      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

  // target: the byte with the bit; walk: set extend flags below it (set)
  // or check the top byte (clear); drop: unflag the byte below a zero byte
  typedef enum logic [1:0] {
    PH_TARGET,
    PH_WALK,
    PH_DROP
  } phase_t;

endpackage

### hw/rtl/fcb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/fax_capability_bitstring.sv
// T.30 DIS/DCS facility bit string store, top level.
// Depends on fcb_pkg and fcb_ram.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------
//   in      | sink      | in_valid/in_ready, kind, bit_number, byte_value, index
//   out     | source    | out_valid/out_ready, bit_set, byte_out, more_follow
//
// One command at a time. clear_all, load_byte and bad bit numbers do no RAM
// read; test_bit and read_byte do one RAM read. set_bit also sets the extend
// flags of bytes 2 to p-1 for target byte p; clear_bit may walk down from the
// top byte. Each byte touched takes a RAM read, then a modify/write step.
// The result waits in an output register; a stalled out_ready holds only the
// final result transfer. Reset (sync, active low) clears the per-entry valid
// bits at once, so no clearing pass is needed.
module fax_capability_bitstring #(
  parameter int NUM_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fcb_pkg::KIND_W-1:0]   in_kind,
  input  logic [fcb_pkg::BITNUM_W-1:0] in_bit_number,
  input  logic [fcb_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [fcb_pkg::ADDR_W-1:0]   in_byte_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_bit_set,
  output logic [fcb_pkg::BYTE_W-1:0]   out_byte_out,
  output logic                        out_more_follow
);

  import fcb_pkg::*;

  localparam logic [ADDR_W:0]   NB_CNT  = (ADDR_W+1)'(NUM_BYTES);
  localparam logic [ADDR_W-1:0] NB_LAST = ADDR_W'(NUM_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_1  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_2  = ADDR_W'(2);

  state_t                 state_r, state_nxt;
  kind_t                  op_r, op_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [ADDR_W-1:0]      cur_r, cur_nxt;
  logic [ADDR_W-1:0]      tgt_r, tgt_nxt;
  logic [BYTE_W-1:0]      mask_r, mask_nxt;
  logic [ADDR_W:0]        pos_r, pos_nxt;
  logic                   past_r, past_nxt;
  logic [STORE_DEPTH-1:0] valid_r, valid_nxt;
  logic                   rd_valid_r;
  logic                   res_bit_r, res_bit_nxt;
  logic [BYTE_W-1:0]      res_byte_r, res_byte_nxt;
  logic                   res_more_r, res_more_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_bit_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_more_r;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]      mem_wdata, mem_rdata;

  logic [BITNUM_W-1:0]    bit_m1;
  logic [ADDR_W-1:0]      bit_byte;
  logic                   bit_ok;
  logic [BYTE_W-1:0]      bit_mask;
  logic [BYTE_W-1:0]      cur_data;
  logic [BYTE_W-1:0]      dropped;
  logic [ADDR_W:0]        cur_inc;
  logic                   mod_done;
  logic                   out_load;
  logic [BYTE_W-1:0]      load_val;

  fcb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign bit_m1   = in_bit_number - BITNUM_W'(1);
  assign bit_byte = bit_m1[BITNUM_W-1:3];
  assign bit_ok   = (in_bit_number != '0) && ({1'b0, bit_byte} < NB_CNT);
  assign bit_mask = 8'h80 >> bit_m1[2:0];

  // entries never written since reset or clear_all read as zero
  assign cur_data = rd_valid_r ? mem_rdata : '0;
  assign dropped  = cur_data & EXT_CLEAR;
  assign cur_inc  = {1'b0, cur_r} + (ADDR_W+1)'(1);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    load_val = past_r ? '0 : in_byte_value;
    if (pos_r[ADDR_W-1:0] == NB_LAST) begin
      load_val = load_val & EXT_CLEAR;
    end
  end

  always_comb begin
    case (op_r)
      K_SET: begin
        if (phase_r == PH_TARGET) begin
          mod_done = (ADDR_2 >= tgt_r);
        end else begin
          mod_done = (cur_inc >= {1'b0, tgt_r});
        end
      end
      K_CLEAR: begin
        case (phase_r)
          PH_TARGET: mod_done = 1'b0;
          PH_WALK:   mod_done = (cur_data != '0);
          default:   mod_done = (dropped != '0) || (cur_r < ADDR_2);
        endcase
      end
      default: mod_done = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((in_kind == K_SET || in_kind == K_CLEAR || in_kind == K_TEST) && bit_ok) begin
            state_nxt = S_MOD;
          end else if (in_kind == K_READ && {1'b0, in_byte_index} < NB_CNT) begin
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD:   state_nxt = S_MOD;
      S_MOD:  state_nxt = mod_done ? S_DONE : S_RD;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt       = op_r;
    phase_nxt    = phase_r;
    cur_nxt      = cur_r;
    tgt_nxt      = tgt_r;
    mask_nxt     = mask_r;
    pos_nxt      = pos_r;
    past_nxt     = past_r;
    valid_nxt    = valid_r;
    res_bit_nxt  = res_bit_r;
    res_byte_nxt = res_byte_r;
    res_more_nxt = res_more_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_r;
    mem_wdata    = cur_data;
    mem_re       = 1'b0;
    mem_raddr    = cur_r;
    in_ready     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_bit_nxt  = 1'b0;
          res_byte_nxt = '0;
          res_more_nxt = 1'b0;
          phase_nxt    = PH_TARGET;
          case (in_kind)
            K_CLEAR_ALL: begin
              valid_nxt = '0;
              pos_nxt   = '0;
              past_nxt  = 1'b0;
            end
            K_LOAD: begin
              if (pos_r < NB_CNT) begin
                mem_we    = 1'b1;
                mem_waddr = pos_r[ADDR_W-1:0];
                mem_wdata = load_val;
                valid_nxt[pos_r[ADDR_W-1:0]] = 1'b1;
                if (pos_r[ADDR_W-1:0] > ADDR_2 && !load_val[0]) begin
                  past_nxt = 1'b1;
                end
                pos_nxt = pos_r + (ADDR_W+1)'(1);
              end
            end
            K_SET, K_CLEAR, K_TEST: begin
              op_nxt    = kind_t'(in_kind);
              mem_re    = bit_ok;
              mem_raddr = bit_byte;
              cur_nxt   = bit_byte;
              tgt_nxt   = bit_byte;
              mask_nxt  = bit_mask;
            end
            K_READ: begin
              op_nxt    = K_READ;
              mem_re    = ({1'b0, in_byte_index} < NB_CNT);
              mem_raddr = in_byte_index;
              cur_nxt   = in_byte_index;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_MOD: begin
        case (op_r)
          K_TEST: res_bit_nxt = |(cur_data & mask_r);
          K_READ: begin
            res_byte_nxt = cur_data;
            res_more_nxt = (cur_r <= ADDR_1) || cur_data[0];
          end
          K_SET: begin
            mem_we = 1'b1;
            valid_nxt[cur_r] = 1'b1;
            phase_nxt = PH_WALK;
            if (phase_r == PH_TARGET) begin
              mem_wdata = cur_data | mask_r;
              cur_nxt   = ADDR_2;
            end else begin
              mem_wdata = cur_data | EXT_FLAG;
              cur_nxt   = cur_inc[ADDR_W-1:0];
            end
          end
          K_CLEAR: begin
            case (phase_r)
              PH_TARGET: begin
                mem_we    = 1'b1;
                mem_wdata = cur_data & ~mask_r;
                valid_nxt[cur_r] = 1'b1;
                cur_nxt   = NB_LAST;
                phase_nxt = PH_WALK;
              end
              PH_WALK: begin
                // top byte zero: go fetch the byte below it
                cur_nxt   = cur_r - ADDR_1;
                phase_nxt = PH_DROP;
              end
              default: begin
                mem_we    = 1'b1;
                mem_wdata = dropped;
                valid_nxt[cur_r] = 1'b1;
                cur_nxt   = cur_r - ADDR_1;
              end
            endcase
          end
          default: ;
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= K_CLEAR_ALL;
      phase_r     <= PH_TARGET;
      pos_r       <= '0;
      past_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      past_r      <= past_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    tgt_r      <= tgt_nxt;
    mask_r     <= mask_nxt;
    res_bit_r  <= res_bit_nxt;
    res_byte_r <= res_byte_nxt;
    res_more_r <= res_more_nxt;
    if (mem_re) begin
      rd_valid_r <= valid_r[mem_raddr];
    end
    if (out_load) begin
      out_bit_r  <= res_bit_r;
      out_byte_r <= res_byte_r;
      out_more_r <= res_more_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_set     = out_bit_r;
  assign out_byte_out    = out_byte_r;
  assign out_more_follow = out_more_r;

endmodule

### hw/rtl/fcb_checker.sv
// Port-level checks for the facility bit string block, bound to the top.
// Depends on fcb_pkg and fax_capability_bitstring.
module fcb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_bit_set,
  input logic [fcb_pkg::BYTE_W-1:0]   out_byte_out,
  input logic                        out_more_follow
);

  import fcb_pkg::*;

  // one command at a time: ready drops right after an input beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a command is in flight");

  // a test answer and a read answer never share a beat
  a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bit_set |-> (out_byte_out == '0) && !out_more_follow)
    else $error("test_bit beat carries read data");

  // a returned byte with its extend flag set always reports a follower
  a_ext_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_out[0] |-> out_more_follow)
    else $error("extend flag set but more_follow low");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_out)
      && $stable(out_bit_set) && $stable(out_more_follow))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fax_capability_bitstring fcb_checker u_fcb_checker (.*);
